// ===== hw/rtl/slerp_pkg.sv =====
// ============================================================================
// slerp_pkg
// Types, widths and constants shared by the quaternion slerp datapath.
// ============================================================================
package slerp_pkg;

    // Component and blend widths
    localparam int COMP_W  = 16;
    localparam int BLEND_W = 17;
    localparam int PROD_W  = 2 * COMP_W;
    localparam int DOT_W   = PROD_W + 2;

    // Q30 internal formats
    localparam int ANG_W  = 34;
    localparam int ROOT_W = 31;
    localparam int REM_W  = 61;
    localparam int DIV_W  = 32;
    localparam int WT_W   = 31;
    localparam int ACC_W  = 49;
    localparam int MUL_W  = ANG_W + BLEND_W + 1;

    localparam logic [BLEND_W-1:0] BLEND_ONE    = 17'd65536;
    localparam logic [ROOT_W-1:0]  Q30_ONE      = 31'h4000_0000;
    localparam logic [ROOT_W-1:0]  DOT_NEAR_ONE = 31'd1073731086;
    localparam logic signed [ANG_W-1:0] GAIN_INV = 34'sd652032874;

    // atan(2^-i) in Q30
    function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:  v = 34'sh03243F6A8;
            1:  v = 34'sh01DAC6705;
            2:  v = 34'sh00FADBAFC;
            3:  v = 34'sh007F56EA6;
            4:  v = 34'sh003FEAB76;
            5:  v = 34'sh001FFD55B;
            6:  v = 34'sh000FFFAAA;
            7:  v = 34'sh0007FFF55;
            8:  v = 34'sh0003FFFEA;
            9:  v = 34'sh0001FFFFD;
            10: v = 34'sh0000FFFFF;
            11: v = 34'sh00007FFFF;
            12: v = 34'sh00003FFFF;
            13: v = 34'sh00001FFFF;
            14: v = 34'sh00000FFFF;
            15: v = 34'sh000007FFF;
            16: v = 34'sh000003FFF;
            17: v = 34'sh000001FFF;
            18: v = 34'sh000000FFF;
            19: v = 34'sh0000007FF;
            20: v = 34'sh0000003FF;
            21: v = 34'sh0000001FF;
            22: v = 34'sh0000000FF;
            23: v = 34'sh00000007F;
            24: v = 34'sh00000003F;
            25: v = 34'sh00000001F;
            26: v = 34'sh00000000F;
            27: v = 34'sh000000008;
            28: v = 34'sh000000004;
            29: v = 34'sh000000002;
            30: v = 34'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic signed [COMP_W-1:0] q1_x;
        logic signed [COMP_W-1:0] q1_y;
        logic signed [COMP_W-1:0] q1_z;
        logic signed [COMP_W-1:0] q1_w;
        logic signed [COMP_W-1:0] q2_x;
        logic signed [COMP_W-1:0] q2_y;
        logic signed [COMP_W-1:0] q2_z;
        logic signed [COMP_W-1:0] q2_w;
        logic [BLEND_W-1:0]       blend;
    } t_slerp_in;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic signed [COMP_W-1:0] out_w;
    } t_slerp_out;

    // Operands that ride alongside the angle and weight cells
    typedef struct packed {
        logic [3:0][COMP_W-1:0] a;
        logic [3:0][COMP_W:0]   b;
        logic [BLEND_W-1:0]     t;
        logic                   lin;
    } t_side;

endpackage

// ===== hw/rtl/quaternion_slerp_top.sv =====
// ============================================================================
// quaternion_slerp_top
// Fixed-point quaternion slerp, one word in and one word out per cycle unless stalled.
// ============================================================================
// The block takes one word per clock while it is not stalled and returns one
// interpolated quaternion per word, in order. Between input and output lie
// rows of cells: 31 square-root cells, a row of vectoring CORDIC cells for the
// angle, two rows of rotation CORDIC cells for the sines and two rows of 31
// divider cells for the weights. The whole pipeline advances together; it
// halts only while the output register holds a word that the sink does not
// take, and o_ready drops during that time.
module quaternion_slerp_top
    import slerp_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_slerp_in  i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_slerp_out o_data
);

    localparam int SIDE_W = $bits(t_side);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << 29;
    localparam int OUT_W = ACC_W - 30;
    localparam logic signed [OUT_W-1:0] SAT_HI = OUT_W'(32767);
    localparam logic signed [OUT_W-1:0] SAT_LO = -OUT_W'(32768);

    logic w_en;
    logic r_out_valid;
    t_slerp_out r_out_data;

    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en;

    // ------------------------------------------------------------------
    // Stage A: component products, saturate blend
    // ------------------------------------------------------------------
    logic signed [COMP_W-1:0] w_q1 [4];
    logic signed [COMP_W-1:0] w_q2 [4];

    always_comb begin
        w_q1[0] = i_data.q1_x; w_q1[1] = i_data.q1_y;
        w_q1[2] = i_data.q1_z; w_q1[3] = i_data.q1_w;
        w_q2[0] = i_data.q2_x; w_q2[1] = i_data.q2_y;
        w_q2[2] = i_data.q2_z; w_q2[3] = i_data.q2_w;
    end

    logic                     r_a_valid;
    logic signed [PROD_W-1:0] r_a_prod [4];
    logic signed [COMP_W-1:0] r_a_q1 [4];
    logic signed [COMP_W-1:0] r_a_q2 [4];
    logic [BLEND_W-1:0]       r_a_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r_a_prod[k] <= w_q1[k] * w_q2[k];
                r_a_q1[k]   <= w_q1[k];
                r_a_q2[k]   <= w_q2[k];
            end
            r_a_t <= (i_data.blend > BLEND_ONE) ? BLEND_ONE : i_data.blend;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: dot, fold to the short arc, clamp to one
    // ------------------------------------------------------------------
    logic signed [DOT_W-1:0] w_dot, w_mag;
    logic                    w_flip;

    always_comb begin
        w_dot = '0;
        for (int k = 0; k < 4; k++) begin
            w_dot = w_dot + {{(DOT_W-PROD_W){r_a_prod[k][PROD_W-1]}}, r_a_prod[k]};
        end
        w_flip = w_dot[DOT_W-1];
        w_mag  = w_flip ? -w_dot : w_dot;
    end

    logic                   r_b_valid;
    logic [ROOT_W-1:0]      r_b_d;
    logic [3:0][COMP_W-1:0] r_b_a;
    logic [3:0][COMP_W:0]   r_b_b;
    logic [BLEND_W-1:0]     r_b_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_d <= (w_mag > {{(DOT_W-ROOT_W){1'b0}}, Q30_ONE}) ? Q30_ONE
                                                                : w_mag[ROOT_W-1:0];
            for (int k = 0; k < 4; k++) begin
                r_b_a[k] <= r_a_q1[k];
                r_b_b[k] <= w_flip ? -{r_a_q2[k][COMP_W-1], r_a_q2[k]}
                                   :  {r_a_q2[k][COMP_W-1], r_a_q2[k]};
            end
            r_b_t <= r_a_t;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: square the dot, flag the near-parallel case
    // ------------------------------------------------------------------
    logic                    r_c_valid;
    logic [2*ROOT_W-1:0]     r_c_dsq;
    logic [ROOT_W-1:0]       r_c_d;
    t_side                   r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_dsq      <= r_b_d * r_b_d;
            r_c_d        <= r_b_d;
            r_c_side.a   <= r_b_a;
            r_c_side.b   <= r_b_b;
            r_c_side.t   <= r_b_t;
            r_c_side.lin <= r_b_d > DOT_NEAR_ONE;
        end
    end

    // ------------------------------------------------------------------
    // Square root cells: s = sqrt(1 - dot^2)
    // ------------------------------------------------------------------
    logic [REM_W-1:0]  w_sq_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] w_sq_root [ROOT_W+1];

    assign w_sq_rem[0]  = (REM_W'(1) << 60) - r_c_dsq[REM_W-1:0];
    assign w_sq_root[0] = '0;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        slerp_sqrt_cell #(.BIT(ROOT_W - 1 - g)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_sq_rem[g]),
            .i_root (w_sq_root[g]),
            .o_rem  (w_sq_rem[g+1]),
            .o_root (w_sq_root[g+1])
        );
    end

    logic              w_s1_valid;
    t_side             w_s1_side;
    logic [ROOT_W-1:0] w_s1_d;

    slerp_delay #(.W(SIDE_W + ROOT_W), .DEPTH(ROOT_W)) u_dly_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c_valid),
        .i_data  ({r_c_side, r_c_d}),
        .o_valid (w_s1_valid),
        .o_data  ({w_s1_side, w_s1_d})
    );

    // Replace a zero root by one LSB
    logic [ROOT_W-1:0] w_s;
    assign w_s = (w_sq_root[ROOT_W] == '0) ? ROOT_W'(1) : w_sq_root[ROOT_W];

    // ------------------------------------------------------------------
    // Vectoring cells: w = atan2(s, dot)
    // ------------------------------------------------------------------
    logic signed [ANG_W-1:0] w_vx [CORDIC_STAGES+1];
    logic signed [ANG_W-1:0] w_vy [CORDIC_STAGES+1];
    logic signed [ANG_W-1:0] w_vz [CORDIC_STAGES+1];

    assign w_vx[0] = $signed({{(ANG_W-ROOT_W){1'b0}}, w_s1_d});
    assign w_vy[0] = $signed({{(ANG_W-ROOT_W){1'b0}}, w_s});
    assign w_vz[0] = '0;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
        slerp_cordic_cell #(.STAGE(g), .VECTOR(1'b1)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (w_vx[g]),
            .i_y   (w_vy[g]),
            .i_z   (w_vz[g]),
            .o_x   (w_vx[g+1]),
            .o_y   (w_vy[g+1]),
            .o_z   (w_vz[g+1])
        );
    end

    logic              w_s2_valid;
    t_side             w_s2_side;
    logic [ROOT_W-1:0] w_s2_s;

    slerp_delay #(.W(SIDE_W + ROOT_W), .DEPTH(CORDIC_STAGES)) u_dly_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s1_valid),
        .i_data  ({w_s1_side, w_s}),
        .o_valid (w_s2_valid),
        .o_data  ({w_s2_side, w_s2_s})
    );

    // ------------------------------------------------------------------
    // Stage M: split the angle by the blend
    // ------------------------------------------------------------------
    logic signed [MUL_W-1:0] w_m_prod0, w_m_prod1;
    logic [BLEND_W-1:0]      w_m_t1;

    always_comb begin
        w_m_t1    = BLEND_ONE - w_s2_side.t;
        w_m_prod0 = {{(MUL_W-ANG_W){w_vz[CORDIC_STAGES][ANG_W-1]}}, w_vz[CORDIC_STAGES]}
                  * $signed({{(MUL_W-BLEND_W){1'b0}}, w_m_t1});
        w_m_prod1 = {{(MUL_W-ANG_W){w_vz[CORDIC_STAGES][ANG_W-1]}}, w_vz[CORDIC_STAGES]}
                  * $signed({{(MUL_W-BLEND_W){1'b0}}, w_s2_side.t});
    end

    logic                    r_m_valid;
    logic signed [ANG_W-1:0] r_m_ang0, r_m_ang1;
    t_side                   r_m_side;
    logic [ROOT_W-1:0]       r_m_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_en) begin
            r_m_valid <= w_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_ang0 <= w_m_prod0[16 +: ANG_W];
            r_m_ang1 <= w_m_prod1[16 +: ANG_W];
            r_m_side <= w_s2_side;
            r_m_s    <= w_s2_s;
        end
    end

    // ------------------------------------------------------------------
    // Rotation cells: sin((1-t)w) and sin(tw)
    // ------------------------------------------------------------------
    logic signed [ANG_W-1:0] w_rx [2][CORDIC_STAGES+1];
    logic signed [ANG_W-1:0] w_ry [2][CORDIC_STAGES+1];
    logic signed [ANG_W-1:0] w_rz [2][CORDIC_STAGES+1];

    assign w_rz[0][0] = r_m_ang0;
    assign w_rz[1][0] = r_m_ang1;

    for (genvar h = 0; h < 2; h++) begin : g_rot
        assign w_rx[h][0] = GAIN_INV;
        assign w_ry[h][0] = '0;
        for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
            slerp_cordic_cell #(.STAGE(g), .VECTOR(1'b0)) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_x   (w_rx[h][g]),
                .i_y   (w_ry[h][g]),
                .i_z   (w_rz[h][g]),
                .o_x   (w_rx[h][g+1]),
                .o_y   (w_ry[h][g+1]),
                .o_z   (w_rz[h][g+1])
            );
        end
    end

    logic              w_s3_valid;
    t_side             w_s3_side;
    logic [ROOT_W-1:0] w_s3_s;

    slerp_delay #(.W(SIDE_W + ROOT_W), .DEPTH(CORDIC_STAGES)) u_dly_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_m_valid),
        .i_data  ({r_m_side, r_m_s}),
        .o_valid (w_s3_valid),
        .o_data  ({w_s3_side, w_s3_s})
    );

    // ------------------------------------------------------------------
    // Stage P: sign and range of each quotient before division
    // ------------------------------------------------------------------
    logic signed [ANG_W-1:0] w_twice_s;
    assign w_twice_s = $signed({{(ANG_W-ROOT_W-1){1'b0}}, w_s3_s, 1'b0});

    logic              r_p_valid;
    logic [DIV_W-1:0]  r_p_rem [2];
    logic [1:0]        r_p_neg, r_p_big;
    t_side             r_p_side;
    logic [ROOT_W-1:0] r_p_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid <= w_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int h = 0; h < 2; h++) begin
                r_p_rem[h] <= w_ry[h][CORDIC_STAGES][DIV_W-1:0];
                r_p_neg[h] <= w_ry[h][CORDIC_STAGES][ANG_W-1];
                r_p_big[h] <= w_ry[h][CORDIC_STAGES] >= w_twice_s;
            end
            r_p_side <= w_s3_side;
            r_p_s    <= w_s3_s;
        end
    end

    // ------------------------------------------------------------------
    // Divider cells: sine * 2^30 / s
    // ------------------------------------------------------------------
    logic [DIV_W-1:0]  w_dr [2][ROOT_W+1];
    logic [ROOT_W-1:0] w_dd [2][ROOT_W+1];
    logic [ROOT_W-1:0] w_dq [2][ROOT_W+1];

    for (genvar h = 0; h < 2; h++) begin : g_div
        assign w_dr[h][0] = r_p_rem[h];
        assign w_dd[h][0] = r_p_s;
        assign w_dq[h][0] = '0;
        for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
            slerp_div_cell #(.BIT(ROOT_W - 1 - g)) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_rem (w_dr[h][g]),
                .i_div (w_dd[h][g]),
                .i_quo (w_dq[h][g]),
                .o_rem (w_dr[h][g+1]),
                .o_div (w_dd[h][g+1]),
                .o_quo (w_dq[h][g+1])
            );
        end
    end

    logic       w_s4_valid;
    t_side      w_s4_side;
    logic [1:0] w_s4_neg, w_s4_big;

    slerp_delay #(.W(SIDE_W + 4), .DEPTH(ROOT_W)) u_dly_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p_valid),
        .i_data  ({r_p_side, r_p_neg, r_p_big}),
        .o_valid (w_s4_valid),
        .o_data  ({w_s4_side, w_s4_neg, w_s4_big})
    );

    // ------------------------------------------------------------------
    // Stage K: clamp weights, or take the linear ones
    // ------------------------------------------------------------------
    logic [WT_W-1:0] w_kq [2];

    always_comb begin
        for (int h = 0; h < 2; h++) begin
            if (w_s4_neg[h]) begin
                w_kq[h] = '0;
            end else if (w_s4_big[h] || (w_dq[h][ROOT_W] > Q30_ONE)) begin
                w_kq[h] = Q30_ONE;
            end else begin
                w_kq[h] = w_dq[h][ROOT_W];
            end
        end
    end

    logic            r_k_valid;
    logic [WT_W-1:0] r_k_w0, r_k_w1;
    t_side           r_k_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_valid <= 1'b0;
        end else if (w_en) begin
            r_k_valid <= w_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_s4_side.lin) begin
                r_k_w0 <= {{(WT_W-BLEND_W){1'b0}}, BLEND_ONE - w_s4_side.t} << 14;
                r_k_w1 <= {{(WT_W-BLEND_W){1'b0}}, w_s4_side.t} << 14;
            end else begin
                r_k_w0 <= w_kq[0];
                r_k_w1 <= w_kq[1];
            end
            r_k_side <= w_s4_side;
        end
    end

    // ------------------------------------------------------------------
    // Stage X: weight each component
    // ------------------------------------------------------------------
    logic                    r_x_valid;
    logic signed [ACC_W-1:0] r_x_p0 [4];
    logic signed [ACC_W-1:0] r_x_p1 [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
        end else if (w_en) begin
            r_x_valid <= r_k_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r_x_p0[k] <= $signed({{(ACC_W-COMP_W){r_k_side.a[k][COMP_W-1]}},
                                      r_k_side.a[k]})
                           * $signed({{(ACC_W-WT_W){1'b0}}, r_k_w0});
                r_x_p1[k] <= $signed({{(ACC_W-COMP_W-1){r_k_side.b[k][COMP_W]}},
                                      r_k_side.b[k]})
                           * $signed({{(ACC_W-WT_W){1'b0}}, r_k_w1});
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: round, saturate, hold while stalled
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0]  w_acc [4];
    logic signed [COMP_W-1:0] w_res [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_acc[k] = r_x_p0[k] + r_x_p1[k] + ROUND_HALF;
            if ($signed(w_acc[k][ACC_W-1:30]) > SAT_HI) begin
                w_res[k] = SAT_HI[COMP_W-1:0];
            end else if ($signed(w_acc[k][ACC_W-1:30]) < SAT_LO) begin
                w_res[k] = SAT_LO[COMP_W-1:0];
            end else begin
                w_res[k] = w_acc[k][30 +: COMP_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_x_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data.out_x <= w_res[0];
            r_out_data.out_y <= w_res[1];
            r_out_data.out_z <= w_res[2];
            r_out_data.out_w <= w_res[3];
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

// ===== hw/rtl/slerp_delay.sv =====
// ============================================================================
// slerp_delay
// Shift line that carries a valid flag and side data past a row of cells.
// ============================================================================
module slerp_delay
    import slerp_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [DEPTH-1:0] r_valid;
    logic [W-1:0]     r_data [DEPTH];

    // Advance the valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < DEPTH; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    // Advance the data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_data[k] <= r_data[k-1];
            end
        end
    end

    assign o_valid = r_valid[DEPTH-1];
    assign o_data  = r_data[DEPTH-1];

endmodule

// ===== hw/rtl/slerp_sqrt_cell.sv =====
// ============================================================================
// slerp_sqrt_cell
// One bit of a digit-by-digit integer square root.
// ============================================================================
module slerp_sqrt_cell
    import slerp_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [ROOT_W-1:0] i_root,
    output logic [REM_W-1:0]  o_rem,
    output logic [ROOT_W-1:0] o_root
);

    localparam int TW = REM_W + 2;

    logic [TW-1:0]     w_trial;
    logic              w_fit;
    logic [REM_W-1:0]  n_rem;
    logic [ROOT_W-1:0] n_root;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    // Try this root bit: (root + 2^b)^2 - root^2
    always_comb begin
        w_trial = ({{(TW-ROOT_W){1'b0}}, i_root} << (BIT + 1)) + (TW'(1) << (2 * BIT));
        w_fit   = {2'b00, i_rem} >= w_trial;
        n_rem   = w_fit ? (i_rem - w_trial[REM_W-1:0]) : i_rem;
        n_root  = w_fit ? (i_root | (ROOT_W'(1) << BIT)) : i_root;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// ===== hw/rtl/slerp_cordic_cell.sv =====
// ============================================================================
// slerp_cordic_cell
// One CORDIC micro-rotation, vectoring or rotation mode.
// ============================================================================
module slerp_cordic_cell
    import slerp_pkg::*;
#(
    parameter int STAGE  = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [ANG_W-1:0] i_x,
    input  logic signed [ANG_W-1:0] i_y,
    input  logic signed [ANG_W-1:0] i_z,
    output logic signed [ANG_W-1:0] o_x,
    output logic signed [ANG_W-1:0] o_y,
    output logic signed [ANG_W-1:0] o_z
);

    logic signed [ANG_W-1:0] w_xs, w_ys, w_ang;
    logic                    w_ccw;
    logic signed [ANG_W-1:0] n_x, n_y, n_z;
    logic signed [ANG_W-1:0] r_x, r_y, r_z;

    // Pick the turn direction: drive y to zero or z to zero
    always_comb begin
        w_xs  = i_x >>> STAGE;
        w_ys  = i_y >>> STAGE;
        w_ang = atan_q30(STAGE);
        w_ccw = VECTOR ? i_y[ANG_W-1] : !i_z[ANG_W-1];
        if (w_ccw) begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - w_ang;
        end else begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ===== hw/rtl/slerp_div_cell.sv =====
// ============================================================================
// slerp_div_cell
// One quotient bit of a restoring divider.
// ============================================================================
module slerp_div_cell
    import slerp_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DIV_W-1:0]  i_rem,
    input  logic [ROOT_W-1:0] i_div,
    input  logic [ROOT_W-1:0] i_quo,
    output logic [DIV_W-1:0]  o_rem,
    output logic [ROOT_W-1:0] o_div,
    output logic [ROOT_W-1:0] o_quo
);

    logic              w_fit;
    logic [DIV_W-1:0]  w_diff;
    logic [DIV_W-1:0]  n_rem;
    logic [ROOT_W-1:0] n_quo;
    logic [DIV_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_div, r_quo;

    // Subtract the divisor when it fits, then shift in a zero
    always_comb begin
        w_fit  = i_rem >= {1'b0, i_div};
        w_diff = w_fit ? (i_rem - {1'b0, i_div}) : i_rem;
        n_rem  = {w_diff[DIV_W-2:0], 1'b0};
        n_quo  = w_fit ? (i_quo | (ROOT_W'(1) << BIT)) : i_quo;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_div <= i_div;
            r_quo <= n_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_div = r_div;
    assign o_quo = r_quo;

endmodule

// ===== hw/rtl/slerp_checker.sv =====
// ============================================================================
// slerp_checker
// Port-level checks on the slerp block's handshake behavior.
// ============================================================================
module slerp_checker
    import slerp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input t_slerp_in  i_data,
    input logic       o_valid,
    input logic       i_ready,
    input t_slerp_out o_data
);

    // Come out of reset with no word on the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word present after reset");

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled output word changed");

    // Take input whenever the output slot is free or drains
    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow the output slot");

    // Hold a waiting input word until it is taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_data))
        else $error("waiting input word changed");

endmodule

bind quaternion_slerp_top slerp_checker u_slerp_checker (.*);

// ===== sim/tb_quaternion_slerp_top.sv =====
// ============================================================================
// tb_quaternion_slerp_top
// Self-checking bench for the fixed-point quaternion slerp pipeline.
// ============================================================================
// A table of directed words runs first: the linear and negative-dot paths,
// blend saturation, output saturation and zero inputs. About 600 random words
// follow. They are mostly close or normalized-looking pairs, so that both the
// linear and the CORDIC paths are reached, plus raw noise. Every result is
// compared field by field with a typed expectation or with a local bit-exact
// model of the datapath. The sender runs in bursts with gaps, and the sink
// stalls on a shifting pattern. Once the sink holds off for a long stretch,
// and once the sender waits for the pipeline to drain.
module tb_quaternion_slerp_top;
    import slerp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSTAGE    = 16;
    localparam int LATENCY   = 70 + 2 * NSTAGE;
    localparam int N_RANDOM  = 600;
    localparam int CYC_LIMIT = 400000;
    localparam longint ONE30 = 64'sd1 << 30;
    localparam longint NEAR1 = 64'sd1073731086;
    localparam longint GAIN  = 64'sd652032874;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    t_slerp_in  i_data = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    t_slerp_out o_data;

    quaternion_slerp_top #(.CORDIC_STAGES(NSTAGE)) DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    typedef struct {
        t_slerp_in  word;
        bit         typed;
        t_slerp_out want;
    } t_row;

    t_row       word_q[$];
    t_slerp_out slerp_q[$];
    int         n_err = 0;
    int         n_in = 0;
    int         n_out = 0;
    int         cycles = 0;
    bit         long_hold_go = 1'b0;

    longint atan_lut[NSTAGE] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF};

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, xs, ys;
        z = 0;
        for (int i = 0; i < NSTAGE; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_lut[i];
            end else begin
                x -= ys; y += xs; z -= atan_lut[i];
            end
        end
        return z;
    endfunction

    function automatic longint rotate_sine(longint z);
        longint x, y, xs, ys;
        x = GAIN;
        y = 0;
        for (int i = 0; i < NSTAGE; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_lut[i];
            end else begin
                x += ys; y -= xs; z += atan_lut[i];
            end
        end
        return y;
    endfunction

    function automatic longint clip_weight(longint k);
        if (k < 0) return 0;
        return (k > ONE30) ? ONE30 : k;
    endfunction

    // Bit-exact slerp of one input word
    function automatic t_slerp_out slerp_of(t_slerp_in w);
        longint a[4], b[4], d, k0, k1, t, s, ang, acc, r;
        longint unsigned rem;
        t_slerp_out res;
        a = '{w.q1_x, w.q1_y, w.q1_z, w.q1_w};
        b = '{w.q2_x, w.q2_y, w.q2_z, w.q2_w};
        t = (w.blend > BLEND_ONE) ? 65536 : longint'(w.blend);
        d = 0;
        for (int i = 0; i < 4; i++) d += a[i] * b[i];
        if (d < 0) begin
            d = -d;
            for (int i = 0; i < 4; i++) b[i] = -b[i];
        end
        if (d > ONE30) d = ONE30;
        if (d > NEAR1) begin
            k0 = (65536 - t) * 16384;
            k1 = t * 16384;
        end else begin
            rem = (64'd1 << 60) - longint'(d * d);
            s = floor_sqrt(rem);
            if (s == 0) s = 1;
            ang = vector_angle(s, d);
            k0 = clip_weight((rotate_sine((ang * (65536 - t)) >>> 16) * ONE30) / s);
            k1 = clip_weight((rotate_sine((ang * t) >>> 16) * ONE30) / s);
        end
        for (int i = 0; i < 4; i++) begin
            acc = a[i] * k0 + b[i] * k1 + (64'sd1 << 29);
            r = acc >>> 30;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            case (i)
                0: res.out_x = r[15:0];
                1: res.out_y = r[15:0];
                2: res.out_z = r[15:0];
                default: res.out_w = r[15:0];
            endcase
        end
        return res;
    endfunction

    function automatic t_slerp_in mk(int ax, int ay, int az, int aw,
                                     int bx, int by, int bz, int bw, int t);
        t_slerp_in w;
        w.q1_x = 16'(ax); w.q1_y = 16'(ay); w.q1_z = 16'(az); w.q1_w = 16'(aw);
        w.q2_x = 16'(bx); w.q2_y = 16'(by); w.q2_z = 16'(bz); w.q2_w = 16'(bw);
        w.blend = 17'(t);
        return w;
    endfunction

    function automatic t_slerp_out quat(int x, int y, int z, int w);
        t_slerp_out o;
        o.out_x = 16'(x); o.out_y = 16'(y); o.out_z = 16'(z); o.out_w = 16'(w);
        return o;
    endfunction

    task automatic add_row(t_slerp_in w, bit typed, t_slerp_out want);
        t_row r;
        r.word = w;
        r.typed = typed;
        r.want = want;
        word_q.push_back(r);
    endtask

    // Directed table: typed results where the linear path makes them obvious
    task automatic build_directed();
        t_slerp_out nil;
        nil = '0;
        // unnormalized equal pair, dot clamped to one, t = 0 gives q1
        add_row(mk(32767, 32767, 0, 0, 32767, 32767, 0, 0, 0), 1,
                quat(32767, 32767, 0, 0));
        // t = one gives q2
        add_row(mk(32767, 32767, 0, 0, 20000, 30000, 100, -5, 65536), 1,
                quat(20000, 30000, 100, -5));
        // blend above one saturates to one
        add_row(mk(32767, 32767, 0, 0, 30000, 32767, 7, 9, 131071), 1,
                quat(30000, 32767, 7, 9));
        // negative dot flips q2 back onto q1
        add_row(mk(32767, 32767, 0, 0, -32767, -32767, 0, 0, 65536), 1,
                quat(32767, 32767, 0, 0));
        // most negative components everywhere
        add_row(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0),
                1, quat(-32768, -32768, -32768, -32768));
        // flipped -32768 becomes +32768 and saturates
        add_row(mk(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768, 65536),
                1, quat(32767, 32767, 32767, 32767));
        // zero inputs, dot zero, CORDIC path
        add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 32768), 0, nil);
        add_row(mk(0, 0, 0, 32767, 0, 0, 0, 0, 65536), 0, nil);
        // unit-ish quaternions just below the linear threshold
        add_row(mk(0, 0, 0, 32767, 0, 0, 0, 32767, 32768), 0, nil);
        add_row(mk(0, 0, 0, 32767, 0, 0, 0, 32767, 0), 0, nil);
        add_row(mk(0, 0, 0, 32767, 0, 0, 0, 32767, 65536), 0, nil);
        // orthogonal pair, quarter-turn blend
        add_row(mk(32767, 0, 0, 0, 0, 32767, 0, 0, 16384), 0, nil);
        add_row(mk(23170, 0, 0, 23170, 0, 23170, 23170, 0, 49152), 0, nil);
        // small dots of both signs, then large ones of both signs
        add_row(mk(23170, 23170, 0, 0, 23170, -23000, 0, 0, 1), 0, nil);
        add_row(mk(23170, 23170, 0, 0, -23170, 23000, 10, 0, 65535), 0, nil);
        add_row(mk(32767, 0, 0, 0, 32700, 2000, 0, 0, 40000), 0, nil);
        add_row(mk(-32768, 0, 0, 0, 32767, 0, 0, 0, 20000), 0, nil);
    endtask

    function automatic int near(int v, int spread);
        int r;
        r = v + $urandom_range(0, 2 * spread) - spread;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    // Random words: close pairs, opposite pairs and noise
    task automatic build_random();
        t_slerp_in w;
        t_slerp_out nil;
        int c[4], sp, mode;
        nil = '0;
        for (int n = 0; n < N_RANDOM; n++) begin
            mode = $urandom_range(0, 9);
            w = t_slerp_in'($bits(t_slerp_in)'({$urandom, $urandom, $urandom,
                                                $urandom, $urandom}));
            if (mode < 7) begin
                for (int i = 0; i < 4; i++)
                    c[i] = 32'($signed(16'($urandom)) >>> $urandom_range(0, 2));
                sp = 1 << $urandom_range(0, 14);
                w.q1_x = 16'(c[0]); w.q1_y = 16'(c[1]);
                w.q1_z = 16'(c[2]); w.q1_w = 16'(c[3]);
                w.q2_x = 16'(near(c[0], sp)); w.q2_y = 16'(near(c[1], sp));
                w.q2_z = 16'(near(c[2], sp)); w.q2_w = 16'(near(c[3], sp));
                if (mode < 2) begin
                    w.q2_x = -w.q2_x; w.q2_y = -w.q2_y;
                    w.q2_z = -w.q2_z; w.q2_w = -w.q2_w;
                end
            end
            if ($urandom_range(0, 7) != 0) w.blend = 17'($urandom_range(0, 65536));
            add_row(w, 0, nil);
        end
    endtask

    // Send words in bursts with gaps; wait for a full drain once mid-run
    initial begin
        t_row r;
        int burst;
        int gap;
        build_directed();
        build_random();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        burst = 0;
        while (word_q.size() != 0) begin
            if (n_in == 400) begin
                i_valid <= 1'b0;
                do @(negedge i_clk); while (slerp_q.size() != 0);
            end
            if (burst == 0) begin
                gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                burst = $urandom_range(1, 40);
            end
            r = word_q.pop_front();
            i_valid <= 1'b1;
            i_data <= r.word;
            do @(posedge i_clk); while (!o_ready);
            if (r.typed) slerp_q.push_back(r.want);
            else slerp_q.push_back(slerp_of(r.word));
            n_in++;
            burst--;
            @(negedge i_clk);
        end
        i_valid <= 1'b0;
        while (slerp_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 20) @(negedge i_clk);
        $display("Covered %0d words in, %0d results out: linear, CORDIC, flip,", n_in,
                 n_out);
        $display("saturation paths, under bursty input, sink stalls and a full stall.");
        if (n_err == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Sink: shifting stall pattern, plus one long hold-off
    initial begin
        logic [15:0] pat;
        int hold;
        pat = 16'hFFFF;
        hold = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!long_hold_go && n_in >= 150) begin
                long_hold_go = 1'b1;
                hold = 3 * LATENCY;
            end
            if (cycles % 64 == 0)
                pat = $urandom_range(0, 2) == 0 ? 16'hFFFF : 16'($urandom);
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= pat[cycles % 16];
            end
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_slerp_out want;
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            n_out <= n_out + 1;
            if (slerp_q.size() == 0) begin
                n_err <= n_err + 1;
                if (n_err < 10) $display("unexpected result word %h", o_data);
            end else begin
                want = slerp_q.pop_front();
                if (want.out_x !== o_data.out_x || want.out_y !== o_data.out_y ||
                    want.out_z !== o_data.out_z || want.out_w !== o_data.out_w) begin
                    n_err <= n_err + 1;
                    if (n_err < 10)
                        $display("result %0d: want %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 n_out, want.out_x, want.out_y, want.out_z, want.out_w,
                                 o_data.out_x, o_data.out_y, o_data.out_z, o_data.out_w);
                end
            end
        end
    end

endmodule
